FILE: rtl/core/gts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gts_pkg
// Shared constants, weight table and types for the temporal smoother.
// ============================================================================
package gts_pkg;

    localparam int RADIUS_DEF        = 21;
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int COORD_W           = 32;
    localparam int FRAME_W           = 16;
    localparam int WEIGHT_W          = 16;
    localparam int ACC_W             = 64;
    localparam int WTAB_LEN          = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_TAP,
        ST_DIVIDE,
        ST_OUT
    } t_state;

    function automatic logic [WEIGHT_W-1:0] gauss_weight(input logic [5:0] k);
        logic [WEIGHT_W-1:0] w;
        case (k)
            6'd1:  w = 16'd64884;
            6'd2:  w = 16'd62966;
            6'd3:  w = 16'd59895;
            6'd4:  w = 16'd55846;
            6'd5:  w = 16'd51039;
            6'd6:  w = 16'd45723;
            6'd7:  w = 16'd40149;
            6'd8:  w = 16'd34557;
            6'd9:  w = 16'd29154;
            6'd10: w = 16'd24109;
            6'd11: w = 16'd19543;
            6'd12: w = 16'd15527;
            6'd13: w = 16'd12093;
            6'd14: w = 16'd9231;
            6'd15: w = 16'd6907;
            6'd16: w = 16'd5066;
            6'd17: w = 16'd3642;
            6'd18: w = 16'd2567;
            6'd19: w = 16'd1773;
            6'd20: w = 16'd1200;
            6'd21: w = 16'd797;
            6'd22: w = 16'd518;
            6'd23: w = 16'd330;
            6'd24: w = 16'd207;
            6'd25: w = 16'd127;
            6'd26: w = 16'd76;
            6'd27: w = 16'd45;
            6'd28: w = 16'd26;
            6'd29: w = 16'd15;
            6'd30: w = 16'd8;
            6'd31: w = 16'd4;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic longint weight_total(input int radius);
        longint s;
        s = 0;
        for (int k = 1; k <= radius; k++) begin
            s = s + longint'(gauss_weight(6'(k)));
        end
        return 2 * s;
    endfunction

endpackage

FILE: rtl/core/gts_if.sv
`timescale 1ns / 1ps
// ============================================================================
// gts_in_if / gts_out_if
// Valid/ready channels for input frames and smoothed results.
// ============================================================================
interface gts_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic              last_frame;
    modport source (output valid, pos_x, pos_y, pos_z, last_frame, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, last_frame, output ready);
endinterface

interface gts_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]       frame_number;
    logic              run_last;
    modport source (output valid, out_x, out_y, out_z, frame_number, run_last,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, frame_number, run_last,
                    output ready);
endinterface

FILE: rtl/core/gts_ring.sv
`timescale 1ns / 1ps
// ============================================================================
// gts_ring
// Frame history memory: one write port, one registered read port.
// ============================================================================
module gts_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [95:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [95:0]   o_rdata
);
    logic [95:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: rtl/core/gts_mac.sv
`timescale 1ns / 1ps
// ============================================================================
// gts_mac
// One axis: weighted tap accumulate, then rounding divide by a constant
// through reciprocal multiplication and a short remainder correction.
// ============================================================================
module gts_mac #(
    parameter longint DEN = gts_pkg::weight_total(gts_pkg::RADIUS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_clr,
    input  logic               i_tap,
    input  logic [15:0]        i_weight,
    input  logic signed [31:0] i_sample,
    input  logic               i_div_start,
    output logic signed [31:0] o_result
);
    import gts_pkg::*;

    localparam int          SH      = $clog2(DEN) - 1;
    localparam longint      RECIP   = (longint'(1) << (31 + SH)) / DEN;
    localparam logic [31:0] RECIP_V = 32'(RECIP);
    localparam logic [63:0] DEN_V   = 64'(DEN);
    localparam logic [63:0] DEN2_V  = 64'(2 * DEN);
    localparam logic [63:0] DEN3_V  = 64'(3 * DEN);
    localparam logic [63:0] HALF_V  = 64'(DEN / 2);
    localparam logic [63:0] SAT_V   = 64'(DEN << 31);

    logic signed [47:0] r_prod;
    logic               r_pvalid;
    logic signed [63:0] r_acc;
    logic [63:0]        r_num;
    logic               r_sat;
    logic [63:0]        r_mq;
    logic [31:0]        r_qe;
    logic [63:0]        r_qd;
    logic [63:0]        r_quo;
    logic               r_neg;
    logic [63:0]        mag;
    logic [63:0]        num_c;
    logic [31:0]        num_top;
    logic [63:0]        rem;
    logic [1:0]         corr;
    logic [63:0]        q_sat;

    always_ff @(posedge i_clk) begin
        r_pvalid <= i_tap;
        r_prod   <= $signed({1'b0, i_weight}) * i_sample;
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_pvalid) begin
            r_acc <= r_acc + 64'(r_prod);
        end
    end

    assign mag     = r_acc[63] ? (~r_acc + 64'd1) : r_acc;
    assign num_c   = mag + HALF_V;
    assign num_top = r_num[SH +: 32];
    assign rem     = r_num - r_qd;
    assign corr    = {1'b0, rem >= DEN_V} + {1'b0, rem >= DEN2_V} + {1'b0, rem >= DEN3_V};

    always_ff @(posedge i_clk) begin
        if (i_div_start) begin
            r_neg <= r_acc[63];
            r_num <= num_c;
            r_sat <= (num_c >= SAT_V);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mq  <= {32'd0, num_top} * {32'd0, RECIP_V};
        r_qe  <= r_mq[62:31];
        r_qd  <= {32'd0, r_mq[62:31]} * DEN_V;
        r_quo <= r_sat ? 64'h8000_0000 : ({32'd0, r_qe} + {62'd0, corr});
    end

    always_comb begin
        if (r_neg) begin
            q_sat = (r_quo > 64'h8000_0000) ? 64'h8000_0000 : r_quo;
            o_result = 32'(~q_sat + 64'd1);
        end else begin
            q_sat = (r_quo > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : r_quo;
            o_result = 32'(q_sat);
        end
    end
endmodule

FILE: rtl/core/gaussian_temporal_smoother_top.sv
`timescale 1ns / 1ps
// ============================================================================
// gaussian_temporal_smoother_top
// Gaussian smoothing of one point trajectory over a frame history memory.
// ============================================================================
// Usage:
//   in  : one request per frame, x/y/z signed Q16.16 plus last_frame mark.
//   out : one request per smoothed frame, with frame_number and run_last.
//   A frame is taken only in idle, while no result is in flight. Each frame
//   writes the history memory; once more than RADIUS frames are pending,
//   the oldest is output. The marked last frame flushes every pending frame.
//   When nothing is output, accept and plan return the block to idle.
//   Smoothed result: plan, taps (one memory read each, one
//   multiply-accumulate per axis, pipeline drain), reciprocal divide, output.
//   Pass-through frames skip the divide. Results lag input by RADIUS frames.
//   Reset clears counters and control; the history memory needs no clear.
//   A stalled receiver holds the result register.
// ============================================================================
module gaussian_temporal_smoother_top #(
    parameter int RADIUS        = gts_pkg::RADIUS_DEF,
    parameter int HISTORY_DEPTH = gts_pkg::HISTORY_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gts_in_if.sink    in_ch,
    gts_out_if.source out_ch
);
    import gts_pkg::*;

    localparam int    AW     = $clog2(HISTORY_DEPTH);
    localparam int    AW1    = AW + 1;
    localparam int    KW     = $clog2(RADIUS + 2);
    localparam longint DEN   = weight_total(RADIUS);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= AW1'(HISTORY_DEPTH)) s = s - AW1'(HISTORY_DEPTH);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        if (a >= b) s = {1'b0, a} - {1'b0, b};
        else        s = {1'b0, a} + AW1'(HISTORY_DEPTH) - {1'b0, b};
        return s[AW-1:0];
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0]      r_wr;
    logic [FRAME_W-1:0] r_recv, r_emit;
    logic [KW-1:0]      r_left;
    logic               r_last;
    logic [KW-1:0]      r_k;
    logic               r_side;
    logic [6:0]         r_cnt;
    logic               r_pass;
    logic [AW-1:0]      r_slot;
    logic [KW-1:0]      r_right;
    logic               r_final;
    logic               r_rd_v;
    logic [KW-1:0]      r_rd_k;

    logic               we;
    logic [AW-1:0]      raddr;
    logic [95:0]        rdata;
    logic [FRAME_W-1:0] pending;
    logic [AW-1:0]      pend_c;
    logic [KW-1:0]      tap_d;
    logic               tap_go;
    logic               clr, div_start;
    logic signed [31:0] res_x, res_y, res_z;

    assign we = in_ch.valid && in_ch.ready;
    assign in_ch.ready = i_rst_n && (r_state == ST_IDLE);
    assign pending = r_recv - r_emit;
    assign pend_c = (pending >= FRAME_W'(HISTORY_DEPTH)) ? AW'(HISTORY_DEPTH - 1)
                                                        : pending[AW-1:0];

    gts_ring #(.DEPTH(HISTORY_DEPTH)) u_ring (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_wr),
        .i_wdata({in_ch.pos_z, in_ch.pos_y, in_ch.pos_x}),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        tap_d = r_side ? ((r_k < r_left) ? r_k : r_left)
                       : ((r_k < r_right) ? r_k : r_right);
        if (r_state == ST_TAP && r_cnt != '0) begin
            raddr = r_side ? ring_sub(r_slot, AW'(tap_d)) : ring_add(r_slot, AW'(tap_d));
        end else begin
            raddr = r_slot;
        end
    end

    assign tap_go = (r_state == ST_TAP) && (r_cnt != '0);
    assign clr    = (r_state == ST_PLAN);

    always_ff @(posedge i_clk) begin
        r_rd_v <= tap_go;
        r_rd_k <= r_k;
    end

    gts_mac #(.DEN(DEN)) u_mx (.i_clk(i_clk), .i_clr(clr), .i_tap(r_rd_v),
        .i_weight(gauss_weight(6'(r_rd_k))), .i_sample(rdata[31:0]),
        .i_div_start(div_start), .o_result(res_x));
    gts_mac #(.DEN(DEN)) u_my (.i_clk(i_clk), .i_clr(clr), .i_tap(r_rd_v),
        .i_weight(gauss_weight(6'(r_rd_k))), .i_sample(rdata[63:32]),
        .i_div_start(div_start), .o_result(res_y));
    gts_mac #(.DEN(DEN)) u_mz (.i_clk(i_clk), .i_clr(clr), .i_tap(r_rd_v),
        .i_weight(gauss_weight(6'(r_rd_k))), .i_sample(rdata[95:64]),
        .i_div_start(div_start), .o_result(res_z));

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE:   if (we) n_state = ST_PLAN;
            ST_PLAN: begin
                if (pending == '0 || (!r_last && pending <= FRAME_W'(RADIUS))) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_TAP;
                end
            end
            ST_TAP: begin
                if (r_cnt == '0) begin
                    if (r_pass) begin
                        n_state = ST_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (r_cnt == 7'd2) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_ch.valid && out_ch.ready) n_state = ST_PLAN;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wr         <= '0;
            r_recv       <= '0;
            r_emit       <= '0;
            r_left       <= '0;
            r_last       <= 1'b0;
            out_ch.valid <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (we) begin
                        r_wr   <= ring_add(r_wr, AW'(1));
                        r_recv <= r_recv + FRAME_W'(1);
                        r_last <= in_ch.last_frame;
                    end
                end
                ST_PLAN: begin
                    r_slot  <= ring_sub(r_wr, pend_c);
                    r_right <= KW'((pend_c - AW'(1)) > AW'(RADIUS) ? AW'(RADIUS)
                                                               : (pend_c - AW'(1)));
                    r_final <= r_last && (pending == FRAME_W'(1));
                    r_pass  <= (r_left == '0) || (pend_c == AW'(1));
                    r_k     <= KW'(1);
                    r_side  <= 1'b0;
                    r_cnt   <= ((r_left == '0) || (pend_c == AW'(1))) ? 7'd1
                                                            : 7'(2 * RADIUS + 2);
                    if (pending == '0 || (!r_last && pending <= FRAME_W'(RADIUS))) begin
                        if (r_last) begin
                            r_recv <= '0;
                            r_emit <= '0;
                            r_left <= '0;
                            r_last <= 1'b0;
                        end
                    end
                end
                ST_TAP: begin
                    if (r_cnt != '0) begin
                        r_cnt  <= r_cnt - 7'd1;
                        r_side <= ~r_side;
                        if (r_cnt <= 7'd3) begin
                            r_k <= '0;
                        end else if (r_side) begin
                            r_k <= r_k + KW'(1);
                        end
                    end else begin
                        r_cnt <= '0;
                    end
                end
                ST_DIVIDE: r_cnt <= r_cnt + 7'd1;
                ST_OUT: begin
                    if (!out_ch.valid) begin
                        out_ch.valid <= 1'b1;
                    end else if (out_ch.ready) begin
                        out_ch.valid <= 1'b0;
                        r_emit       <= r_emit + FRAME_W'(1);
                        if (r_left < KW'(RADIUS)) r_left <= r_left + KW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && !out_ch.valid) begin
            out_ch.out_x        <= r_pass ? rdata[31:0]  : res_x;
            out_ch.out_y        <= r_pass ? rdata[63:32] : res_y;
            out_ch.out_z        <= r_pass ? rdata[95:64] : res_z;
            out_ch.frame_number <= r_emit;
            out_ch.run_last     <= r_final;
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
    a_left_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= KW'(RADIUS)) else $error("left reach overflow");
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (r_state == ST_OUT)) else $error("result outside output");
`endif
endmodule

FILE: sim/gaussian_temporal_smoother_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gaussian_temporal_smoother_top_tb
// Drives directed and random frame trajectories into the smoother,
// predicts every smoothed frame from a local frame history, and checks each
// result field by field, with and without random sender and receiver stalls.
// ============================================================================
module gaussian_temporal_smoother_top_tb;
    import gts_pkg::*;

    localparam int RAD   = RADIUS_DEF;
    localparam int DEPTH = HISTORY_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_frame;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        fnum;
        logic               last;
    } t_smoothed;

    logic i_clk;
    logic i_rst_n;

    gts_in_if  in_ch ();
    gts_out_if out_ch ();

    gaussian_temporal_smoother_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    // predictor state
    logic signed [31:0] hist [DEPTH][3];
    logic [15:0]        n_taken;
    logic [15:0]        n_sent;
    int unsigned        wslot;
    int unsigned        reach;

    t_frame    pending_frames[$];
    t_smoothed expected_frames[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_send;
    bit  in_fire;
    int  errors;
    int  watchdog;
    int  n_checked;
    int  n_accepted;

    const int unsigned wtab [31] = '{
        64884, 62966, 59895, 55846, 51039, 45723, 40149, 34557,
        29154, 24109, 19543, 15527, 12093, 9231, 6907, 5066,
        3642, 2567, 1773, 1200, 797, 518, 330, 207,
        127, 76, 45, 26, 15, 8, 4
    };

    function automatic logic signed [31:0] gauss_mean(int unsigned slot, int unsigned lft,
                                                      int unsigned rgt, int ax);
        longint acc;
        longint den;
        longint q;
        int unsigned r;
        int unsigned l;
        acc = 0;
        den = 0;
        for (int k = 1; k <= RAD; k++) den += 2 * longint'(wtab[k-1]);
        for (int unsigned k = 1; k <= RAD; k++) begin
            r = (k < rgt) ? k : rgt;
            l = (k < lft) ? k : lft;
            acc += longint'(wtab[k-1]) * (longint'(hist[(slot + r) % DEPTH][ax])
                   + longint'(hist[(slot + DEPTH - l) % DEPTH][ax]));
        end
        if (acc >= 0) q = (acc + den / 2) / den;
        else          q = -((-acc + den / 2) / den);
        if (q > 64'sd2147483647)  q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic predict_smoothed(input t_frame f);
        int unsigned pend;
        int unsigned slot;
        int unsigned rgt;
        bit          fin;
        t_smoothed   s;
        logic signed [31:0] v [3];
        hist[wslot][0] = f.x;
        hist[wslot][1] = f.y;
        hist[wslot][2] = f.z;
        wslot = (wslot + 1) % DEPTH;
        n_taken = n_taken + 16'd1;
        forever begin
            pend = 16'(n_taken - n_sent);
            if (pend == 0) break;
            if (!f.last && pend <= RAD) break;
            if (pend >= DEPTH) pend = DEPTH - 1;
            slot = (wslot + DEPTH - pend) % DEPTH;
            rgt  = pend - 1;
            fin  = f.last && pend == 1;
            for (int a = 0; a < 3; a++) begin
                if (reach == 0 || rgt == 0) v[a] = hist[slot][a];
                else                        v[a] = gauss_mean(slot, reach, rgt, a);
            end
            s.x = v[0]; s.y = v[1]; s.z = v[2];
            s.fnum = n_sent;
            s.last = fin;
            expected_frames = {expected_frames, s};
            n_sent = n_sent + 16'd1;
            if (reach < RAD) reach++;
            if (fin) break;
        end
        if (f.last) begin
            n_taken = 0;
            n_sent  = 0;
            reach   = 0;
        end
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_trajectory(input int len);
        t_frame f;
        for (int i = 0; i < len; i++) begin
            f.x = pick_coord();
            f.y = pick_coord();
            f.z = pick_coord();
            f.last = (i == len - 1);
            pending_frames = {pending_frames, f};
        end
    endtask

    task automatic drain_all();
        wait (pending_frames.size() == 0);
        @(posedge i_clk);
        while (in_ch.valid || expected_frames.size() != 0) @(posedge i_clk);
    endtask

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (!hold_send && pending_frames.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.valid      <= 1'b1;
                in_ch.pos_x      <= pending_frames[0].x;
                in_ch.pos_y      <= pending_frames[0].y;
                in_ch.pos_z      <= pending_frames[0].z;
                in_ch.last_frame <= pending_frames[0].last;
                void'(pending_frames.pop_front());
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_frame    f;
        t_smoothed e;
        bit        hit;
        hit = 1'b0;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                f.x = in_ch.pos_x;
                f.y = in_ch.pos_y;
                f.z = in_ch.pos_z;
                f.last = in_ch.last_frame;
                predict_smoothed(f);
                n_accepted <= n_accepted + 1;
                hit = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                hit = 1'b1;
                n_checked <= n_checked + 1;
                if (expected_frames.size() == 0) begin
                    $error("unexpected result for frame %0d", out_ch.frame_number);
                    errors++;
                end else begin
                    e = expected_frames.pop_front();
                    if (out_ch.out_x !== e.x) begin
                        $error("out_x exp %0d got %0d", e.x, out_ch.out_x); errors++;
                    end
                    if (out_ch.out_y !== e.y) begin
                        $error("out_y exp %0d got %0d", e.y, out_ch.out_y); errors++;
                    end
                    if (out_ch.out_z !== e.z) begin
                        $error("out_z exp %0d got %0d", e.z, out_ch.out_z); errors++;
                    end
                    if (out_ch.frame_number !== e.fnum) begin
                        $error("frame_number exp %0d got %0d", e.fnum,
                               out_ch.frame_number);
                        errors++;
                    end
                    if (out_ch.run_last !== e.last) begin
                        $error("run_last exp %0d got %0d", e.last, out_ch.run_last);
                        errors++;
                    end
                end
            end
            watchdog <= hit ? 0 : watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d results still expected", expected_frames.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        t_frame f;
        errors = 0; watchdog = 0; n_checked = 0; n_accepted = 0;
        hold_send = 0; in_fire = 0;
        n_taken = 0; n_sent = 0; wslot = 0; reach = 0;
        send_idle_pct = 27; recv_idle_pct = 71;
        in_ch.valid = 0; in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
        in_ch.last_frame = 0; out_ch.ready = 0;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // single frame, two frames, twenty frames of extremes
        f = '{x: 32'sh7FFFFFFF, y: 32'sh80000000, z: 32'sh0, last: 1'b1};
        pending_frames = {pending_frames, f};
        f = '{x: 32'sh80000000, y: 32'sh7FFFFFFF, z: -32'sd1, last: 1'b0};
        pending_frames = {pending_frames, f};
        f.last = 1'b1;
        pending_frames = {pending_frames, f};
        for (int i = 0; i < 20; i++) begin
            f.x = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
            f.y = 32'sh7FFFFFFF;
            f.z = 32'sh80000000;
            f.last = (i == 19);
            pending_frames = {pending_frames, f};
        end

        // wait until the flush has fully drained, then hold the sender idle
        drain_all();
        hold_send = 1;
        repeat (20) @(posedge i_clk);
        hold_send = 0;

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 71; recv_idle_pct = 27; end
            if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            queue_trajectory($urandom_range(1, 3));
            queue_trajectory($urandom_range(20, 23));
            queue_trajectory($urandom_range(30, 45));
            drain_all();
        end
        repeat (200) @(posedge i_clk);
        $display("Covered %0d input frames and %0d smoothed results over three stall mixes,",
                 n_accepted, n_checked);
        $display("including single-frame, short and window-filling trajectories.");
        if (errors == 0 && expected_frames.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
